// ===== hdl/sfv_pkg.sv =====
// Package for the spring force vector unit: widths, payload types, helpers.
// Used by every module under hdl but sfv_checker; depends on nothing.
package sfv_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int POS_W   = 32;
    localparam int REG_W   = 31;
    localparam int DIFF_W  = 33;              // magnitude of a 34-bit difference
    localparam int SUM_W   = 68;              // sum of three squares
    localparam int ROOT_W  = 34;              // floor(sqrt) of SUM_W bits
    localparam int NUM_W   = DIFF_W + REG_W + ROOT_W;   // |d|*k*|s|
    localparam int QUO_W   = 32;              // quotient incl. saturation bit
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPRING_CONSTANT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH     = 1'b1;

    localparam logic [REG_W-1:0] SPRING_CONSTANT_RESET = REG_W'(65536);
    localparam logic [REG_W-1:0] REST_LENGTH_RESET     = '0;

endpackage

// ===== hdl/sfv_sqrt_stage.sv =====
// One restoring square root step (one result bit) as a registered stage.
// Depends on sfv_pkg; instantiated in a chain by the top level.
module sfv_sqrt_stage
    import sfv_pkg::*;
#(
    parameter int BIT_POS = 0
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [SUM_W-1:0]  rem_in,
    input  logic [ROOT_W-1:0] root_in,
    output logic [SUM_W-1:0]  rem_out,
    output logic [ROOT_W-1:0] root_out
);
    // Trial value (2*root*2^b + 2^2b), remainder kept as s - root^2
    logic [SUM_W+1:0] trial;
    logic             take;

    always_comb begin
        trial = ({36'd0, root_in} << (BIT_POS + 1)) + ((SUM_W+2)'(1) << (2 * BIT_POS));
        take  = {2'b00, rem_in} >= trial;
    end

    // Advance on enable
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out  <= take ? rem_in - trial[SUM_W-1:0] : rem_in;
            root_out <= take ? root_in | (ROOT_W'(1) << BIT_POS) : root_in;
        end
    end
endmodule

// ===== hdl/sfv_div_stage.sv =====
// One restoring division step (one quotient bit) for three lanes at once.
// Depends on sfv_pkg; instantiated in a chain by the top level.
module sfv_div_stage
    import sfv_pkg::*;
#(
    parameter int BIT_POS = 0
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [ROOT_W+23:0]      den,
    input  logic [2:0][NUM_W-1:0]   num_in,
    input  logic [2:0][QUO_W-1:0]   quo_in,
    output logic [2:0][NUM_W-1:0]   num_out,
    output logic [2:0][QUO_W-1:0]   quo_out
);
    logic [NUM_W+31:0] shifted;

    always_comb begin
        shifted = {{(NUM_W-ROOT_W+8){1'b0}}, den} << BIT_POS;
    end

    // Subtract where the shifted divisor fits, per lane
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if ({32'd0, num_in[i]} >= shifted) begin
                    num_out[i] <= num_in[i] - shifted[NUM_W-1:0];
                    quo_out[i] <= quo_in[i] | (QUO_W'(1) << BIT_POS);
                end else begin
                    num_out[i] <= num_in[i];
                    quo_out[i] <= quo_in[i];
                end
            end
        end
    end
endmodule

// ===== hdl/spring_force_vector_unit.sv =====
// Top level of the spring force vector unit: Hooke's law force per position pair.
// Depends on sfv_pkg, sfv_sqrt_stage and sfv_div_stage.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: mass x,y,z then partner x,y,z (32 b each)
//  m_axis    | out       | tdata: force x,y,z (32 b each)
//  cfg       | in        | cfg_wr_en, cfg_index, cfg_data (k, rest length)
//
// One transaction enters per cycle while the pipeline advances; the depth is set
// by the bit-per-stage square root and divide chains.
// The whole pipeline advances together and halts while the output register is
// full and m_axis_tready is low; nothing is dropped or repeated.
// aresetn clears the valid bits and sets k and rest length to their reset values; payload is not reset.
module spring_force_vector_unit
    import sfv_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // mass_pos_x, mass_pos_y, mass_pos_z, partner_pos_x, partner_pos_y, partner_pos_z
    input  logic [6*POS_W-1:0]   s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // force_x, force_y, force_z
    output logic [3*POS_W-1:0]   m_axis_tdata
);
    localparam int NSQ = ROOT_W;
    localparam int NDV = QUO_W;
    localparam int DEPTH = 2 + NSQ + 3 + NDV + 1;

    logic [REG_W-1:0] k_reg, rest_reg;
    logic [DEPTH-1:0] vld_reg;
    logic             adv;

    // Advance everything unless the last stage holds an untaken result
    assign adv           = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= SPRING_CONSTANT_RESET;
            rest_reg <= REST_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SPRING_CONSTANT: k_reg    <= cfg_data;
                CFG_REST_LENGTH:     rest_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    // Stage 0: differences, split to sign and magnitude
    logic [2:0][DIFF_W-1:0] ad0_reg;
    logic [2:0]             nd0_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [DIFF_W:0] d;
                d = $signed({{2{s_axis_tdata[i*POS_W+POS_W-1]}}, s_axis_tdata[i*POS_W +: POS_W]})
                    - $signed({{2{s_axis_tdata[(i+3)*POS_W+POS_W-1]}},
                               s_axis_tdata[(i+3)*POS_W +: POS_W]});
                nd0_reg[i] <= d[DIFF_W];
                ad0_reg[i] <= d[DIFF_W] ? DIFF_W'(-d) : d[DIFF_W-1:0];
            end
        end
    end

    // Stage 1: sum of squares
    logic [SUM_W-1:0] sum1_reg;
    logic [2:0][DIFF_W-1:0] ad1_reg;
    logic [2:0]             nd1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            sum1_reg <= SUM_W'(ad0_reg[0]) * SUM_W'(ad0_reg[0])
                      + SUM_W'(ad0_reg[1]) * SUM_W'(ad0_reg[1])
                      + SUM_W'(ad0_reg[2]) * SUM_W'(ad0_reg[2]);
            ad1_reg <= ad0_reg;
            nd1_reg <= nd0_reg;
        end
    end

    // Square root chain, one bit per stage, most significant first
    logic [SUM_W-1:0]       sq_rem    [NSQ+1];
    logic [ROOT_W-1:0]      sq_root   [NSQ+1];
    logic [2:0][DIFF_W-1:0] sq_ad_reg [NSQ+1];
    logic [2:0]             sq_nd_reg [NSQ+1];
    assign sq_rem[0]    = sum1_reg;
    assign sq_root[0]   = '0;
    always_comb begin
        sq_ad_reg[0] = ad1_reg;
        sq_nd_reg[0] = nd1_reg;
    end
    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        sfv_sqrt_stage #(.BIT_POS(NSQ - 1 - g)) u_stage (
            .aclk(aclk), .en(adv),
            .rem_in(sq_rem[g]), .root_in(sq_root[g]),
            .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1])
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_ad_reg[g+1] <= sq_ad_reg[g];
                sq_nd_reg[g+1] <= sq_nd_reg[g];
            end
        end
    end

    // Stage A: spring extension, sign and magnitude; |d|*k per lane
    logic [ROOT_W-1:0]                len_a_reg;
    logic [ROOT_W:0]                  as_a_reg;
    logic                             ns_a_reg;
    logic [2:0][DIFF_W+REG_W-1:0]     dk_a_reg;
    logic [2:0]                       nd_a_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            logic signed [ROOT_W+1:0] s;
            s = $signed({2'b00, sq_root[NSQ]}) - $signed({{(ROOT_W-REG_W+2){1'b0}}, rest_reg});
            len_a_reg <= sq_root[NSQ];
            ns_a_reg  <= s[ROOT_W+1];
            as_a_reg  <= s[ROOT_W+1] ? (ROOT_W+1)'(-s) : s[ROOT_W:0];
            for (int i = 0; i < 3; i++)
                dk_a_reg[i] <= sq_ad_reg[NSQ][i] * k_reg;
            nd_a_reg <= sq_nd_reg[NSQ];
        end
    end

    // Stage B: low and high partial products of |d|*k and |s|
    localparam int DK_W = DIFF_W + REG_W;
    logic [2:0][DK_W+16:0]  plo_b_reg;
    logic [2:0][DK_W+17:0]  phi_b_reg;
    logic [ROOT_W-1:0]      len_b_reg;
    logic [2:0]             nf_b_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                plo_b_reg[i] <= dk_a_reg[i] * as_a_reg[16:0];
                phi_b_reg[i] <= dk_a_reg[i] * as_a_reg[ROOT_W:17];
                nf_b_reg[i]  <= !(nd_a_reg[i] ^ ns_a_reg);
            end
            len_b_reg <= len_a_reg;
        end
    end

    // Stage C: combine partial products
    logic [2:0][NUM_W-1:0]  num_c_reg;
    logic [ROOT_W-1:0]      len_c_reg;
    logic [2:0]             nf_c_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++)
                num_c_reg[i] <= NUM_W'(plo_b_reg[i]) + (NUM_W'(phi_b_reg[i]) << 17);
            len_c_reg <= len_b_reg;
            nf_c_reg  <= nf_b_reg;
        end
    end

    // Divide chain: saturation bit first, then bits 30 down to 0
    logic [ROOT_W+23:0] den_c;
    assign den_c = (ROOT_W+24)'(len_c_reg) << FRAC_BITS;
    logic [2:0][NUM_W-1:0] dv_num     [NDV+1];
    logic [2:0][QUO_W-1:0] dv_quo     [NDV+1];
    logic [ROOT_W+23:0]    dv_den_reg [NDV+1];
    logic [2:0]            dv_nf_reg  [NDV+1];
    logic                  dv_z_reg   [NDV+1];
    assign dv_num[0] = num_c_reg;
    assign dv_quo[0] = '0;
    always_comb begin
        dv_den_reg[0] = den_c;
        dv_nf_reg[0]  = nf_c_reg;
        dv_z_reg[0]   = (len_c_reg == '0);
    end
    for (genvar g = 0; g < NDV; g++) begin : g_div
        sfv_div_stage #(.BIT_POS(NDV - 1 - g)) u_stage (
            .aclk(aclk), .en(adv), .den(dv_den_reg[g]),
            .num_in(dv_num[g]), .quo_in(dv_quo[g]),
            .num_out(dv_num[g+1]), .quo_out(dv_quo[g+1])
        );
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_den_reg[g+1] <= dv_den_reg[g];
                dv_nf_reg[g+1]  <= dv_nf_reg[g];
                dv_z_reg[g+1]   <= dv_z_reg[g];
            end
        end
    end

    // Output stage: zero length, saturation to either end, then sign
    logic [3*POS_W-1:0] out_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                logic [QUO_W-1:0] q;
                q = dv_quo[NDV][i];
                if (dv_z_reg[NDV])
                    out_reg[i*POS_W +: POS_W] <= '0;
                else if (q[QUO_W-1])
                    out_reg[i*POS_W +: POS_W] <= dv_nf_reg[NDV][i] ? 32'h8000_0000
                                                                   : 32'h7FFF_FFFF;
                else if (dv_nf_reg[NDV][i])
                    out_reg[i*POS_W +: POS_W] <= POS_W'(-q);
                else
                    out_reg[i*POS_W +: POS_W] <= q;
            end
        end
    end
    assign m_axis_tdata = out_reg;
endmodule

// ===== hdl/sfv_checker.sv =====
// Port-level checker for the spring force vector unit, bound to the top level.
// Depends on sfv_pkg through the top level's port widths only.
module sfv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    // A stalled result holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // Input is taken whenever the output side is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // No result right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result after reset");
endmodule

bind spring_force_vector_unit sfv_checker u_sfv_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

// ===== tb/tb_spring_force_vector_unit.sv =====
// Self-checking testbench for spring_force_vector_unit: directed table, then random phases.
// Depends on sfv_pkg and the unit under hdl; forces are predicted in-bench and scored in order.
`timescale 1ns / 100ps

module tb_spring_force_vector_unit;
    import sfv_pkg::*;

    localparam int FRAC = DEFAULT_FRAC_BITS;
    localparam int DRAIN_CYCLES = 100;        // exceeds the pipeline depth
    localparam logic [REG_W-1:0] K_MAX = '1;
    localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] P_MIN = 32'sh8000_0000;

    typedef logic signed [31:0] coord_t;
    typedef struct {
        coord_t x, y, z;
    } vec_t;
    typedef struct {
        logic [REG_W-1:0] k, rest;
        vec_t             mass, partner;
        bit               typed;
        vec_t             spring_out;
    } row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // mass_pos_x, mass_pos_y, mass_pos_z, partner_pos_x, partner_pos_y, partner_pos_z
    logic [6*POS_W-1:0]   s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // force_x, force_y, force_z
    logic [3*POS_W-1:0]   m_axis_tdata;

    logic [REG_W-1:0] stiffness = SPRING_CONSTANT_RESET;
    logic [REG_W-1:0] natural_len = REST_LENGTH_RESET;
    vec_t             pending_force[$];
    bit               typed_q[$];
    vec_t             typed_force_q[$];
    int               errors = 0;
    bit               idle_on = 1'b1;
    bit               hold_request = 1'b0;

    spring_force_vector_unit u_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Hooke's law force with exact intermediates, truncated once, saturated to 32 bits
    function automatic vec_t spring_force(vec_t m, vec_t p, logic [REG_W-1:0] k,
                                          logic [REG_W-1:0] rest);
        coord_t           mc[3], pc[3];
        logic signed [33:0] d;
        logic [32:0]      ad[3];
        bit               neg_d[3];
        logic [67:0]      sq;
        logic [33:0]      root, trial;
        logic signed [35:0] s;
        logic [33:0]      as;
        logic [127:0]     num, den, q;
        logic [31:0]      f[3];
        vec_t             r;
        mc = '{m.x, m.y, m.z};
        pc = '{p.x, p.y, p.z};
        sq = '0;
        for (int i = 0; i < 3; i++) begin
            d = {{2{mc[i][31]}}, mc[i]} - {{2{pc[i][31]}}, pc[i]};
            neg_d[i] = d[33];
            ad[i] = neg_d[i] ? 33'(-d) : 33'(d);
            sq += 68'(ad[i]) * 68'(ad[i]);
        end
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = root | (34'd1 << b);
            if (68'(trial) * 68'(trial) <= sq) root = trial;
        end
        s = $signed({2'b0, root}) - $signed({5'b0, rest});
        as = s[35] ? 34'(-s) : 34'(s);
        for (int i = 0; i < 3; i++) begin
            if (root == 0) begin
                f[i] = '0;
            end else begin
                num = 128'(ad[i]) * 128'(k) * 128'(as);
                den = 128'(root) << FRAC;
                q = num / den;
                if (q >= 128'h8000_0000) q = 128'h8000_0000;
                if (q == 0) f[i] = '0;
                else if (neg_d[i] == s[35]) f[i] = 32'(-q);
                else f[i] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            end
        end
        r.x = f[0];
        r.y = f[1];
        r.z = f[2];
        return r;
    endfunction

    // Log each accepted input transaction with its predicted force
    always @(posedge aclk) begin
        vec_t m, p;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            {p.z, p.y, p.x, m.z, m.y, m.x} = s_axis_tdata;
            pending_force.insert(pending_force.size(),
                                 spring_force(m, p, stiffness, natural_len));
        end
    end

    // Compare each output transaction with the oldest prediction
    always @(posedge aclk) begin
        vec_t want, tw;
        logic [31:0] gx, gy, gz;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            {gz, gy, gx} = m_axis_tdata;
            if (pending_force.size() == 0) begin
                report("unexpected force_x", gx, 'x);
            end else begin
                want = pending_force.pop_front();
                if (gx !== want.x) report("force_x", gx, want.x);
                if (gy !== want.y) report("force_y", gy, want.y);
                if (gz !== want.z) report("force_z", gz, want.z);
                if (typed_q.pop_front()) begin
                    tw = typed_force_q.pop_front();
                    if (tw.x != want.x) report("table force_x", want.x, tw.x);
                    if (tw.y != want.y) report("table force_y", want.y, tw.y);
                    if (tw.z != want.z) report("table force_z", want.z, tw.z);
                end
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold_request && hold == 0) begin
                hold = 400;
                hold_request = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(99) < 15);
            end
        end
    end

    task automatic send_pair(vec_t m, vec_t p, bit typed, vec_t tf);
        if (idle_on && $urandom_range(99) < 6) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        typed_q.insert(typed_q.size(), typed);
        if (typed) typed_force_q.insert(typed_force_q.size(), tf);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p.z, p.y, p.x, m.z, m.y, m.x};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Drop valid, wait for every prediction to be met, then let the pipe empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_force.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_spring(logic [REG_W-1:0] k, logic [REG_W-1:0] rest);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SPRING_CONSTANT;
        cfg_data <= k;
        @(posedge aclk);
        cfg_index <= CFG_REST_LENGTH;
        cfg_data <= rest;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        stiffness = k;
        natural_len = rest;
        @(posedge aclk);
    endtask

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    initial begin
        row_t  rows[$];
        row_t  r;
        vec_t  z, m, p, nf;
        logic [REG_W-1:0] k, rest;
        int    pick;

        z = '{0, 0, 0};
        nf = z;
        // k, rest, mass, partner, typed, spring_out
        rows = '{
            '{SPRING_CONSTANT_RESET, REST_LENGTH_RESET, z, z, 1, z},
            '{SPRING_CONSTANT_RESET, REST_LENGTH_RESET, '{P_MAX, P_MAX, P_MAX},
              '{P_MAX, P_MAX, P_MAX}, 1, z},
            '{SPRING_CONSTANT_RESET, REST_LENGTH_RESET, '{P_MIN, P_MIN, P_MIN},
              '{P_MIN, P_MIN, P_MIN}, 1, z},
            '{SPRING_CONSTANT_RESET, REST_LENGTH_RESET, '{65536, 0, 0}, z, 1,
              '{-65536, 0, 0}},
            '{SPRING_CONSTANT_RESET, REST_LENGTH_RESET, '{0, -65536, 0}, z, 1,
              '{0, 65536, 0}},
            '{SPRING_CONSTANT_RESET, REST_LENGTH_RESET, '{0, 0, 65536}, z, 1,
              '{0, 0, -65536}},
            '{SPRING_CONSTANT_RESET, REST_LENGTH_RESET, '{P_MAX, P_MAX, P_MAX},
              '{P_MIN, P_MIN, P_MIN}, 1, '{P_MIN, P_MIN, P_MIN}},
            '{SPRING_CONSTANT_RESET, REST_LENGTH_RESET, '{P_MIN, P_MIN, P_MIN},
              '{P_MAX, P_MAX, P_MAX}, 1, '{P_MAX, P_MAX, P_MAX}},
            '{SPRING_CONSTANT_RESET, 131072, '{131072, 0, 0}, z, 1, z},
            '{SPRING_CONSTANT_RESET, 131072, '{65536, 0, 0}, z, 0, z},
            '{SPRING_CONSTANT_RESET, 131072, '{0, 3 * 65536, -4 * 65536}, z, 0, z},
            '{0, 131072, '{12345, -678, 910}, '{-4, 5, 6}, 1, z},
            '{K_MAX, 0, '{1, 0, 0}, z, 0, z},
            '{K_MAX, 0, '{-70000, 80000, 123}, '{0, -90000, 5}, 0, z},
            '{K_MAX, K_MAX, '{65536, 65536, 65536}, z, 0, z},
            '{K_MAX, K_MAX, '{P_MAX, P_MAX, P_MAX}, '{P_MIN, P_MIN, P_MIN}, 0, z},
            '{K_MAX, K_MAX, '{P_MIN, 0, P_MAX}, '{P_MAX, 0, P_MIN}, 0, z},
            '{0, K_MAX, '{P_MAX, P_MIN, 7}, z, 1, z},
            '{SPRING_CONSTANT_RESET, REST_LENGTH_RESET, '{1, 1, 1}, z, 0, z}
        };

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; registers change only between drained rows
        foreach (rows[i]) begin
            r = rows[i];
            if (r.k != stiffness || r.rest != natural_len) set_spring(r.k, r.rest);
            send_pair(r.mass, r.partner, r.typed, r.spring_out);
        end

        // Random phases, each under its own spring setting
        for (int ph = 0; ph < 8; ph++) begin
            unique case (ph)
                0: begin
                    k = SPRING_CONSTANT_RESET;
                    rest = REG_W'($urandom_range(0, 1 << 20));
                end
                1: begin k = K_MAX; rest = '0; end
                2: begin k = REG_W'($urandom_range(1, 1 << 22)); rest = K_MAX; end
                3: begin k = '0; rest = REG_W'($urandom_range(0, 1 << 18)); end
                default: begin k = REG_W'($urandom); rest = REG_W'($urandom); end
            endcase
            if (ph == 6) rest = REG_W'($urandom_range(0, 1 << 21));
            set_spring(k, rest);
            idle_on = (ph != 2);
            if (ph == 4) hold_request = 1'b1;
            for (int n = 0; n < 130; n++) begin
                pick = $urandom_range(99);
                m = '{rand_coord(), rand_coord(), rand_coord()};
                if (pick < 55) begin
                    // nearby partner, the usual spring geometry
                    p.x = m.x + coord_t'($urandom_range(0, 1 << 21)) - (1 << 20);
                    p.y = m.y + coord_t'($urandom_range(0, 1 << 21)) - (1 << 20);
                    p.z = m.z + coord_t'($urandom_range(0, 1 << 21)) - (1 << 20);
                end else if (pick < 62) begin
                    p = m;
                end else if (pick < 70) begin
                    // length close to the rest length along one axis
                    p = m;
                    p.x = m.x - coord_t'(natural_len) + coord_t'($urandom_range(0, 8)) - 4;
                end else if (pick < 78) begin
                    m.x = ($urandom_range(1)) ? P_MAX : P_MIN;
                    p = '{($urandom_range(1)) ? P_MAX : P_MIN, rand_coord(),
                          ($urandom_range(1)) ? P_MAX : P_MIN};
                end else begin
                    p = '{rand_coord(), rand_coord(), rand_coord()};
                end
                send_pair(m, p, 1'b0, nf);
            end
        end

        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sfv_pkg.sv
hdl/sfv_sqrt_stage.sv
hdl/sfv_div_stage.sv
hdl/spring_force_vector_unit.sv
hdl/sfv_checker.sv
tb/tb_spring_force_vector_unit.sv
